// ===== rtl/icos_pkg.sv =====
package icos_pkg;

  // Default configuration of the angle word and the rotator chain.
  localparam int ICOS_ANGLE_BITS   = 32;
  localparam int ICOS_CORDIC_STEPS = 16;

  // Datapath widths of the rotator: x and y hold seed coordinates times 2^20 plus growth.
  localparam int XW = 55;
  localparam int ZW = 34;

  // Dividend width of the bit-serial dividers.
  localparam int DIV_BITS = 65;

  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0] CORDIC_GAIN  = 32'h26DD_3B6A;
  // 2*pi*5/27 in Q.22, turns radius/period into km/s.
  localparam logic [22:0] SPEED_K      = 23'd4880294;
  localparam logic [22:0] SPEED_MAX    = 23'h7F_FFFF;

  // Arctangent of 2^-k as a fraction of a turn.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RADIUS    = 3'd0,
    CFG_PERIOD    = 3'd1,
    CFG_ROT       = 3'd2,
    CFG_INCL      = 3'd3,
    CFG_NODE      = 3'd4,
    CFG_COMPACT   = 3'd5,
    CFG_SCALE     = 3'd6,
    CFG_CENTRAL   = 3'd7
  } cfg_idx_e;

  // What a request in the rotator chain computes.
  typedef enum logic [1:0] {
    T_VEC  = 2'd0,
    T_ORB  = 2'd1,
    T_INC  = 2'd2,
    T_NODE = 2'd3
  } tag_e;

  // One request travelling down the rotator chain.
  typedef struct packed {
    logic                 valid;
    tag_e                 tag;
    logic                 vec;
    logic                 neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

// ===== rtl/icos_if.sv =====
interface icos_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        step_days;
  logic signed [31:0] seed_x;
  logic signed [31:0] seed_z;

  modport source(output valid, action, step_days, seed_x, seed_z, input ready);
  modport sink(input valid, action, step_days, seed_x, seed_z, output ready);
endinterface

interface icos_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic signed [23:0] vel_z;
  logic [31:0]        phase_out;
  logic [31:0]        spin_out;

  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, phase_out,
                 spin_out, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, phase_out,
               spin_out, output ready);
endinterface

// ===== rtl/icos_cell.sv =====
module icos_cell
  import icos_pkg::*;
#(
  parameter int K = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  logic signed [XW-1:0] shx, shy;
  logic                 sigma;
  logic signed [ZW-1:0] ang;
  cordic_t              nxt;

  // One micro-rotation; vectoring drives y to zero, rotation drives z to zero.
  always_comb begin
    shx   = cell_i.x >>> K;
    shy   = cell_i.y >>> K;
    sigma = cell_i.vec ? ~cell_i.y[XW-1] : cell_i.z[ZW-1];
    ang   = signed'({{(ZW-32){1'b0}}, ATAN_TURNS[K]});
    nxt   = cell_i;
    if (sigma) begin
      nxt.x = cell_i.x + shy;
      nxt.y = cell_i.y - shx;
      nxt.z = cell_i.z + ang;
    end else begin
      nxt.x = cell_i.x - shy;
      nxt.y = cell_i.y + shx;
      nxt.z = cell_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o <= '0;
    end else begin
      cell_o <= nxt;
    end
  end

endmodule

// ===== rtl/icos_div.sv =====
module icos_div
  import icos_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DIV_BITS-1:0] dividend_i,
  input  logic [31:0]         divisor_i,
  output logic                done_o,
  output logic [31:0]         quot_o,
  output logic                hi_o
);

  localparam int CW = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0] dvd_q;
  logic [31:0]         dsr_q, rem_q, quot_q;
  logic                hi_q, busy_q, done_q;
  logic [CW-1:0]       cnt_q;
  logic [32:0]         rem_sh, rem_sub;
  logic                qbit;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIV_BITS-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    qbit    = (rem_sh >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits above the low word only raise the high flag.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
      hi_q   <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DIV_BITS-2:0], 1'b0};
      rem_q  <= qbit ? rem_sub[31:0] : rem_sh[31:0];
      quot_q <= {quot_q[30:0], qbit};
      hi_q   <= hi_q | quot_q[31];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign hi_o   = hi_q;

endmodule

// ===== rtl/inclined_circular_orbit_step.sv =====
// Channel  Dir  Handshake      Payload
// req_i    in   valid/ready    action, step_days, seed_x, seed_z
// rsp_o    out  valid/ready    pos_x/y/z, vel_x/y/z, phase_out, spin_out
// cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One request at a time. Three bit-serial dividers run side by side, then the rotator chain
// turns the orbit, inclination and node angles into cosine and sine (after a vectoring pass
// for a seed), and the shared multiplier forms eighteen products one after another. The
// result is held until rsp_o.ready; req_i.ready is high only while no request is in flight.
// Reset clears the phases and the sequencer and loads the configuration defaults.
module inclined_circular_orbit_step
  import icos_pkg::*;
#(
  parameter int ANGLE_BITS   = ICOS_ANGLE_BITS,
  parameter int CORDIC_STEPS = ICOS_CORDIC_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  icos_in_if.sink     req_i,
  icos_out_if.source  rsp_o
);

  localparam logic [31:0] PMASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_VEC  = 6'b000100,
    S_ROT  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    M_PY1, M_PZ1, M_VY1, M_VZ1, M_U0A, M_U0B, M_U2A, M_U2B, M_V0A, M_V0B,
    M_V2A, M_V2B, M_PX, M_PY, M_PZ, M_VX, M_VY, M_VZ
  } mstep_e;

  // Configuration registers.
  logic [31:0]        radius_q, period_q;
  logic signed [31:0] rot_q;
  logic [15:0]        incl_q, node_q, scale_q;
  logic               compact_q, central_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= '0;
      period_q  <= '0;
      rot_q     <= '0;
      incl_q    <= '0;
      node_q    <= '0;
      compact_q <= 1'b0;
      scale_q   <= 16'd131;
      central_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS:  radius_q  <= cfg_data_i;
        CFG_PERIOD:  period_q  <= cfg_data_i;
        CFG_ROT:     rot_q     <= cfg_data_i;
        CFG_INCL:    incl_q    <= cfg_data_i[15:0];
        CFG_NODE:    node_q    <= cfg_data_i[15:0];
        CFG_COMPACT: compact_q <= cfg_data_i[0];
        CFG_SCALE:   scale_q   <= cfg_data_i[15:0];
        CFG_CENTRAL: central_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic               accept;
  logic               orb_moving, spin_moving, rot_neg;
  logic [31:0]        rot_mag;
  logic [33:0]        sd3;
  logic [54:0]        spd_num;
  logic [47:0]        cmp_prod;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign orb_moving  = !central_q && (period_q != '0);
  assign spin_moving = !central_q && (rot_q != '0);
  assign rot_neg     = rot_q[31];
  assign rot_mag     = rot_neg ? 32'(0 - rot_q) : rot_q;
  assign sd3         = {2'b0, req_i.step_days} + {1'b0, req_i.step_days, 1'b0};
  assign spd_num     = radius_q * SPEED_K;
  assign cmp_prod    = radius_q * scale_q;

  // Dividers: orbit step, spin step and orbital speed.
  logic        dv_done [3];
  logic [31:0] dv_quot [3];
  logic        dv_hi   [3];

  icos_div u_div_orb (
    .clk_i, .rst_ni, .start_i(accept),
    .dividend_i({5'b0, req_i.step_days, 28'b0}), .divisor_i(period_q),
    .done_o(dv_done[0]), .quot_o(dv_quot[0]), .hi_o(dv_hi[0])
  );

  icos_div u_div_spin (
    .clk_i, .rst_ni, .start_i(accept),
    .dividend_i({sd3, 31'b0}), .divisor_i(rot_mag),
    .done_o(dv_done[1]), .quot_o(dv_quot[1]), .hi_o(dv_hi[1])
  );

  icos_div u_div_spd (
    .clk_i, .rst_ni, .start_i(accept),
    .dividend_i({10'b0, spd_num}), .divisor_i(period_q),
    .done_o(dv_done[2]), .quot_o(dv_quot[2]), .hi_o(dv_hi[2])
  );

  logic div_done;
  assign div_done = dv_done[0] & dv_done[1] & dv_done[2];

  // Rotator chain.
  cordic_t ch [CORDIC_STEPS+1];
  cordic_t cho;
  assign cho = ch[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    icos_cell #(.K(i)) u_cell (.clk_i, .rst_ni, .cell_i(ch[i]), .cell_o(ch[i+1]));
  end

  logic [31:0]        orbit_q, spin_q, reff_q;
  logic [22:0]        speed_q;
  logic               seed_q, seed_zero_q;
  logic signed [31:0] sx_q, sz_q;
  logic [1:0]         fcnt_q;

  // Chain feed: one vectoring request for a seed, then three angles.
  logic [31:0]          ang, qa, qq;
  logic signed [XW-1:0] vx0, vy0;
  tag_e                 ftag;

  always_comb begin
    case (fcnt_q)
      2'd0:    ftag = T_ORB;
      2'd1:    ftag = T_INC;
      default: ftag = T_NODE;
    endcase
    case (ftag)
      T_INC:   ang = {incl_q, 16'b0};
      T_NODE:  ang = {node_q, 16'b0};
      default: ang = orbit_q;
    endcase
    qa  = ang & PMASK;
    qq  = qa + TURN_QUARTER;
    vx0 = {{(XW-52){sx_q[31]}}, sx_q, 20'b0};
    vy0 = {{(XW-52){sz_q[31]}}, sz_q, 20'b0};
    ch[0] = '0;
    if (state_q == S_VEC && fcnt_q == 2'd0) begin
      ch[0].valid = 1'b1;
      ch[0].tag   = T_VEC;
      ch[0].vec   = 1'b1;
      ch[0].x     = sx_q[31] ? -vx0 : vx0;
      ch[0].y     = sx_q[31] ? -vy0 : vy0;
      ch[0].z     = sx_q[31] ? ZW'(TURN_HALF) : '0;
    end else if (state_q == S_ROT && fcnt_q != 2'd3) begin
      ch[0].valid = 1'b1;
      ch[0].tag   = ftag;
      ch[0].neg   = qq[31];
      ch[0].x     = XW'(signed'(CORDIC_GAIN));
      ch[0].z     = ZW'(signed'(qq[31] ? qa + TURN_HALF : qa));
    end
  end

  logic signed [XW-1:0] xo, yo;
  assign xo = cho.neg ? -cho.x : cho.x;
  assign yo = cho.neg ? -cho.y : cho.y;

  // Shared multiplier and its operand selection.
  mstep_e             mstep_q;
  logic               mph_q;
  logic signed [31:0] c_q, s_q, ci_q, si_q, co_q, so_q;
  logic signed [33:0] py1_q, pz1_q, vy1_q, vz1_q, u0_q, u2_q, v0_q, v2_q;
  logic signed [33:0] ma, mb, c34, s34, ns34, ci34, si34, co34, so34, reff34, spd34;
  logic signed [67:0] mul_q;
  logic signed [37:0] r;

  always_comb begin
    c34    = 34'(c_q);
    s34    = 34'(s_q);
    ns34   = -s34;
    ci34   = 34'(ci_q);
    si34   = 34'(si_q);
    co34   = 34'(co_q);
    so34   = 34'(so_q);
    reff34 = signed'({2'b0, reff_q});
    spd34  = signed'({11'b0, speed_q});
    case (mstep_q)
      M_PY1:   begin ma = s34;   mb = si34;   end
      M_PZ1:   begin ma = s34;   mb = ci34;   end
      M_VY1:   begin ma = c34;   mb = si34;   end
      M_VZ1:   begin ma = c34;   mb = ci34;   end
      M_U0A:   begin ma = c34;   mb = co34;   end
      M_U0B:   begin ma = pz1_q; mb = so34;   end
      M_U2A:   begin ma = c34;   mb = so34;   end
      M_U2B:   begin ma = pz1_q; mb = co34;   end
      M_V0A:   begin ma = ns34;  mb = co34;   end
      M_V0B:   begin ma = vz1_q; mb = so34;   end
      M_V2A:   begin ma = ns34;  mb = so34;   end
      M_V2B:   begin ma = vz1_q; mb = co34;   end
      M_PX:    begin ma = u0_q;  mb = reff34; end
      M_PY:    begin ma = py1_q; mb = reff34; end
      M_PZ:    begin ma = u2_q;  mb = reff34; end
      M_VX:    begin ma = v0_q;  mb = spd34;  end
      M_VY:    begin ma = vy1_q; mb = spd34;  end
      default: begin ma = v2_q;  mb = spd34;  end
    endcase
  end

  assign r = mul_q[67:30];

  function automatic logic [31:0] sat32(logic signed [37:0] v);
    if (v > 38'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -38'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [23:0] sat24(logic signed [37:0] v);
    if (v > 38'sh0_007F_FFFF) begin
      return 24'h7F_FFFF;
    end else if (v < -38'sh0_0080_0000) begin
      return 24'h80_0000;
    end
    return v[23:0];
  endfunction

  logic [31:0] px_q, py_q, pz_q;
  logic [23:0] vx_q, vy_q, vz_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      orbit_q <= '0;
      spin_q  <= '0;
      fcnt_q  <= '0;
      mstep_q <= M_PY1;
      mph_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fcnt_q <= '0;
            if (seed_q) begin
              state_q <= S_VEC;
            end else begin
              state_q <= S_ROT;
              if (orb_moving) begin
                orbit_q <= (orbit_q + dv_quot[0]) & PMASK;
              end
              if (spin_moving) begin
                spin_q <= (rot_neg ? spin_q - dv_quot[1] : spin_q + dv_quot[1]) & PMASK;
              end
            end
          end
        end
        S_VEC: begin
          if (fcnt_q == 2'd0) begin
            fcnt_q <= 2'd1;
          end
          if (cho.valid && cho.tag == T_VEC) begin
            orbit_q <= seed_zero_q ? '0 : cho.z[31:0] & PMASK;
            fcnt_q  <= '0;
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          if (fcnt_q != 2'd3) begin
            fcnt_q <= fcnt_q + 2'd1;
          end
          if (cho.valid && cho.tag == T_NODE) begin
            mstep_q <= M_PY1;
            mph_q   <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          mph_q <= ~mph_q;
          if (mph_q) begin
            if (mstep_q == M_VZ) begin
              state_q <= S_OUT;
            end else begin
              mstep_q <= mstep_e'(mstep_q + 5'd1);
            end
          end
        end
        S_OUT: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request capture, speed, trig results and the product write-back.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      seed_q      <= req_i.action;
      sx_q        <= req_i.seed_x;
      sz_q        <= req_i.seed_z;
      seed_zero_q <= (req_i.seed_x == '0) && (req_i.seed_z == '0);
      reff_q      <= compact_q ? cmp_prod[47:16] : radius_q;
    end
    if (state_q == S_DIV && div_done) begin
      if (!orb_moving) begin
        speed_q <= '0;
      end else if (dv_hi[2] || dv_quot[2][31:29] != 3'd0) begin
        speed_q <= SPEED_MAX;
      end else begin
        speed_q <= dv_quot[2][28:6];
      end
    end
    if (cho.valid) begin
      case (cho.tag)
        T_ORB:   begin c_q  <= xo[31:0]; s_q  <= yo[31:0]; end
        T_INC:   begin ci_q <= xo[31:0]; si_q <= yo[31:0]; end
        T_NODE:  begin co_q <= xo[31:0]; so_q <= yo[31:0]; end
        default: ;
      endcase
    end
    if (state_q == S_MUL) begin
      if (!mph_q) begin
        mul_q <= ma * mb;
      end else begin
        case (mstep_q)
          M_PY1:   py1_q <= -r[33:0];
          M_PZ1:   pz1_q <= r[33:0];
          M_VY1:   vy1_q <= -r[33:0];
          M_VZ1:   vz1_q <= r[33:0];
          M_U0A:   u0_q  <= r[33:0];
          M_U0B:   u0_q  <= u0_q + r[33:0];
          M_U2A:   u2_q  <= -r[33:0];
          M_U2B:   u2_q  <= u2_q + r[33:0];
          M_V0A:   v0_q  <= r[33:0];
          M_V0B:   v0_q  <= v0_q + r[33:0];
          M_V2A:   v2_q  <= -r[33:0];
          M_V2B:   v2_q  <= v2_q + r[33:0];
          M_PX:    px_q  <= sat32(r);
          M_PY:    py_q  <= sat32(r);
          M_PZ:    pz_q  <= sat32(r);
          M_VX:    vx_q  <= sat24(r);
          M_VY:    vy_q  <= sat24(r);
          default: vz_q  <= sat24(r);
        endcase
      end
    end
  end

  assign rsp_o.valid     = (state_q == S_OUT);
  assign rsp_o.pos_x     = px_q;
  assign rsp_o.pos_y     = py_q;
  assign rsp_o.pos_z     = pz_q;
  assign rsp_o.vel_x     = vx_q;
  assign rsp_o.vel_y     = vy_q;
  assign rsp_o.vel_z     = vz_q;
  assign rsp_o.phase_out = orbit_q;
  assign rsp_o.spin_out  = spin_q;

endmodule

// ===== rtl/icos_check.sv =====
module icos_check (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // The block never takes a request while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("request taken with a result pending");

  // A result never shows up the cycle after a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i)
    else $error("result appeared too early");

  // Once the result is taken, the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i && !out_valid_i)
    else $error("block did not return to idle");

endmodule

bind inclined_circular_orbit_step icos_check u_icos_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready)
);
